[rtl/rdq_pkg.sv]
// ----------------------------------------------------------------------------
// rdq_pkg
// types and constants shared by the red drop queue
// ----------------------------------------------------------------------------
package rdq_pkg;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_DROP_POLICY = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_THRESH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_THRESH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_PROB    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_AVG_WEIGHT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CAPACITY    = 3'd5;

    localparam logic [1:0] POLICY_RANDOM   = 2'd0;
    localparam logic [1:0] POLICY_CLASS    = 2'd1;
    localparam logic [1:0] POLICY_PRIORITY = 2'd2;

    localparam logic [1:0] CLASS_BACKGROUND = 2'd3;

    localparam int unsigned ENTRY_W = 21;

    typedef struct packed {
        logic        kind;
        logic [15:0] packet_id;
        logic [2:0]  packet_priority;
        logic [1:0]  app_class;
        logic [15:0] red_random;
        logic [15:0] drop_random;
    } rdq_in_t;

    typedef struct packed {
        logic        accepted;
        logic        early_dropped;
        logic        victim_valid;
        logic [15:0] victim_id;
        logic [2:0]  victim_priority;
        logic        departed_valid;
        logic [15:0] departed_id;
        logic [2:0]  departed_priority;
        logic [1:0]  departed_class;
        logic [4:0]  occupancy;
        logic [19:0] average_occupancy;
    } rdq_out_t;

    typedef struct packed {
        logic [15:0] id;
        logic [2:0]  prio;
        logic [1:0]  cls;
    } rdq_entry_t;

endpackage

[rtl/rdq_ram.sv]
// ----------------------------------------------------------------------------
// rdq_ram
// generic ram with one write port and one registered read port
// ----------------------------------------------------------------------------
module rdq_ram #(
    parameter int unsigned WIDTH = 21,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/red_drop_policy_packet_queue.sv]
// ----------------------------------------------------------------------------
// red_drop_policy_packet_queue
// packet queue with random early detection admission and overflow victim rule
// ----------------------------------------------------------------------------
// one transaction at a time; the next is taken once the previous result has left
// an arrival updates the average, then runs the red test, which may drop it early,
// then appends; over the limit a victim is chosen by priority, class or random index,
// read and removed by shifting later entries; a departure reads and removes the head
// reset clears count, average and result, sets register defaults; store is not cleared
module red_drop_policy_packet_queue
    import rdq_pkg::*;
#(
    parameter int unsigned DEPTH = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  rdq_in_t               in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output rdq_out_t              out_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_EWMA, S_RED, S_TEST, S_APPEND, S_MOD, S_SRCH_RD, S_SRCH,
        S_PICK, S_VREAD, S_VCAPT, S_SHIFT_RD, S_SHIFT_WR, S_DONE
    } state_t;

    state_t      state_reg;
    rdq_in_t     item_reg;
    rdq_out_t    res_reg;
    logic        out_valid_reg;
    logic [CW-1:0] count_reg;
    logic [20:0] avg_reg;
    logic [1:0]  pol_reg;
    logic [4:0]  min_reg, max_reg;
    logic [15:0] prob_reg, wgt_reg;
    logic [3:0]  cap_reg;
    logic [CW-1:0] idx_reg;
    logic [CW-1:0] best_reg;
    logic [2:0]  best_prio_reg;
    logic        found_reg;
    logic [15:0] rem_reg;
    logic [3:0]  mod_step_reg;
    logic [37:0] prod_a_reg, prod_b_reg;

    logic            ram_we;
    logic [AW-1:0]   ram_waddr, ram_raddr;
    rdq_entry_t      ram_wdata, ram_rdata;
    logic [CW-1:0]   limit;
    logic [CW:0]     cap_ext;
    logic [15:0]     rem_shift, rem_new;

    rdq_ram #(.WIDTH(ENTRY_W), .DEPTH(DEPTH)) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign in_ready  = (state_reg == S_IDLE) && !out_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = res_reg;

    always_comb
    begin
        cap_ext = (CW + 1)'(cap_reg);
        if (cap_ext > (CW + 1)'(DEPTH - 1))
        begin
            limit = CW'(DEPTH - 1);
        end
        else
        begin
            limit = cap_ext[CW-1:0];
        end
    end

    // restoring remainder step for the random victim index
    always_comb
    begin
        rem_shift = {rem_reg[14:0], item_reg.drop_random[mod_step_reg]};
        if (rem_shift >= 16'(count_reg))
        begin
            rem_new = rem_shift - 16'(count_reg);
        end
        else
        begin
            rem_new = rem_shift;
        end
    end

    // store access: read address and write port driven from state
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = idx_reg[AW-1:0];
        ram_wdata = ram_rdata;
        ram_raddr = idx_reg[AW-1:0];
        case (state_reg)
            S_APPEND:
            begin
                ram_we    = 1'b1;
                ram_waddr = count_reg[AW-1:0];
                ram_wdata = '{id: item_reg.packet_id, prio: item_reg.packet_priority,
                              cls: item_reg.app_class};
            end
            S_SHIFT_RD:
            begin
                ram_raddr = AW'(idx_reg + CW'(1));
            end
            S_SHIFT_WR:
            begin
                ram_we = 1'b1;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            item_reg      <= '0;
            res_reg       <= '0;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
            avg_reg       <= '0;
            pol_reg       <= POLICY_PRIORITY;
            min_reg       <= 5'd5;
            max_reg       <= 5'd15;
            prob_reg      <= 16'd6554;
            wgt_reg       <= 16'd131;
            cap_reg       <= 4'd10;
            idx_reg       <= '0;
            best_reg      <= '0;
            best_prio_reg <= '0;
            found_reg     <= 1'b0;
            rem_reg       <= '0;
            mod_step_reg  <= '0;
            prod_a_reg    <= '0;
            prod_b_reg    <= '0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_DROP_POLICY: pol_reg  <= cfg_data[1:0];
                    REG_MIN_THRESH:  min_reg  <= cfg_data[4:0];
                    REG_MAX_THRESH:  max_reg  <= cfg_data[4:0];
                    REG_MAX_PROB:    prob_reg <= cfg_data;
                    REG_AVG_WEIGHT:  wgt_reg  <= cfg_data;
                    REG_CAPACITY:    cap_reg  <= cfg_data[3:0];
                    default:         pol_reg  <= pol_reg;
                endcase
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && in_ready)
                    begin
                        item_reg <= in_data;
                        res_reg  <= '0;
                        idx_reg  <= '0;
                        if (!in_data.kind)
                        begin
                            prod_a_reg <= 38'((17'h10000 - 17'(wgt_reg)) * avg_reg);
                            prod_b_reg <= 38'({wgt_reg, 16'd0} * 21'(count_reg));
                            state_reg  <= S_EWMA;
                        end
                        else if (count_reg != '0)
                        begin
                            // head read, then removal shifts from 0
                            state_reg <= S_VREAD;
                        end
                        else
                        begin
                            state_reg <= S_DONE;
                        end
                    end
                end
                S_EWMA:
                begin
                    avg_reg <= 21'((prod_a_reg + prod_b_reg) >> 16);
                    state_reg <= S_RED;
                end
                S_RED:
                begin
                    prod_a_reg <= 38'({item_reg.red_random * 21'(max_reg - min_reg), 16'd0});
                    prod_b_reg <= 38'(prob_reg * (avg_reg - {min_reg, 16'd0}));
                    if (avg_reg < {min_reg, 16'd0})
                    begin
                        state_reg <= S_APPEND;
                    end
                    else if (avg_reg >= {max_reg, 16'd0})
                    begin
                        res_reg.early_dropped <= 1'b1;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        state_reg <= S_TEST;
                    end
                end
                S_TEST:
                begin
                    if (prod_a_reg < prod_b_reg)
                    begin
                        res_reg.early_dropped <= 1'b1;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        state_reg <= S_APPEND;
                    end
                end
                S_APPEND:
                begin
                    res_reg.accepted <= 1'b1;
                    count_reg <= count_reg + CW'(1);
                    if (count_reg + CW'(1) > limit)
                    begin
                        res_reg.victim_valid <= 1'b1;
                        idx_reg <= '0;
                        best_reg <= '0;
                        best_prio_reg <= '0;
                        found_reg <= 1'b0;
                        if (pol_reg == POLICY_RANDOM)
                        begin
                            rem_reg <= '0;
                            mod_step_reg <= 4'd15;
                            state_reg <= S_MOD;
                        end
                        else
                        begin
                            state_reg <= S_SRCH_RD;
                        end
                    end
                    else
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_MOD:
                begin
                    // one remainder bit per cycle
                    rem_reg <= rem_new;
                    if (mod_step_reg == 4'd0)
                    begin
                        idx_reg <= CW'(rem_new);
                        state_reg <= S_VREAD;
                    end
                    else
                    begin
                        mod_step_reg <= mod_step_reg - 4'd1;
                    end
                end
                S_SRCH_RD:
                begin
                    state_reg <= S_SRCH;
                end
                S_SRCH:
                begin
                    // ram_rdata holds entry idx_reg
                    if (pol_reg == POLICY_CLASS)
                    begin
                        if (!found_reg && ram_rdata.cls == CLASS_BACKGROUND)
                        begin
                            found_reg <= 1'b1;
                            best_reg <= idx_reg;
                        end
                    end
                    else if (idx_reg == '0 || ram_rdata.prio > best_prio_reg)
                    begin
                        best_reg <= idx_reg;
                        best_prio_reg <= ram_rdata.prio;
                    end
                    if (idx_reg + CW'(1) >= count_reg)
                    begin
                        state_reg <= S_PICK;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + CW'(1);
                        state_reg <= S_SRCH_RD;
                    end
                end
                S_PICK:
                begin
                    // no background entry: the head goes
                    idx_reg <= (pol_reg == POLICY_CLASS && !found_reg) ? CW'(0) : best_reg;
                    state_reg <= S_VREAD;
                end
                S_VREAD:
                begin
                    state_reg <= S_VCAPT;
                end
                S_VCAPT:
                begin
                    // ram_rdata holds entry idx_reg
                    if (item_reg.kind)
                    begin
                        res_reg.departed_valid <= 1'b1;
                        res_reg.departed_id <= ram_rdata.id;
                        res_reg.departed_priority <= ram_rdata.prio;
                        res_reg.departed_class <= ram_rdata.cls;
                    end
                    else
                    begin
                        res_reg.victim_id <= ram_rdata.id;
                        res_reg.victim_priority <= ram_rdata.prio;
                    end
                    state_reg <= S_SHIFT_RD;
                end
                S_SHIFT_RD:
                begin
                    if (idx_reg + CW'(1) >= count_reg)
                    begin
                        count_reg <= count_reg - CW'(1);
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        state_reg <= S_SHIFT_WR;
                    end
                end
                S_SHIFT_WR:
                begin
                    idx_reg <= idx_reg + CW'(1);
                    state_reg <= S_SHIFT_RD;
                end
                S_DONE:
                begin
                    res_reg.occupancy <= 5'(count_reg);
                    res_reg.average_occupancy <= avg_reg[20] ? 20'hFFFFF : avg_reg[19:0];
                    out_valid_reg <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

[tb/red_drop_policy_packet_queue_test.sv]
// ----------------------------------------------------------------------------
// red_drop_policy_packet_queue_test
// drives arrivals and departures through the red drop queue over several
// register settings and checks every result against a built-in predictor
// ----------------------------------------------------------------------------
module red_drop_policy_packet_queue_test;
    import rdq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 16;
    localparam int WATCHDOG_LIMIT = 20000;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    rdq_in_t               in_data = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    rdq_out_t              out_data;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    red_drop_policy_packet_queue #(.DEPTH(DEPTH)) DUT (.*);

    always #5 clk = ~clk;

    // predictor state
    logic [1:0]  p_policy;
    logic [4:0]  p_min_th;
    logic [4:0]  p_max_th;
    logic [15:0] p_max_prob;
    logic [15:0] p_weight;
    logic [3:0]  p_capacity;
    rdq_entry_t  q_store [DEPTH];
    int unsigned q_count;
    logic [63:0] q_avg;

    rdq_in_t  pending_items [$];
    rdq_out_t expected_results [$];
    int       errors = 0;
    int       idle_cycles = 0;
    int       hold_cycles = 0;

    function automatic void queue_item(rdq_in_t it);
        pending_items = {pending_items, it};
    endfunction

    function automatic void remove_entry(int unsigned idx);
        for (int unsigned i = idx; i + 1 < q_count; i++)
            q_store[i] = q_store[i + 1];
        q_count--;
    endfunction

    function automatic int unsigned choose_victim(logic [15:0] rnd);
        int unsigned best;
        best = 0;
        if (p_policy == POLICY_RANDOM)
            return rnd % q_count;
        if (p_policy == POLICY_CLASS)
        begin
            for (int unsigned i = 0; i < q_count; i++)
                if (q_store[i].cls == CLASS_BACKGROUND)
                    return i;
            return 0;
        end
        for (int unsigned i = 1; i < q_count; i++)
            if (q_store[i].prio > q_store[best].prio)
                best = i;
        return best;
    endfunction

    function automatic bit red_rejects(logic [15:0] rnd);
        logic [63:0] mn, mx, lhs, rhs;
        mn = 64'(p_min_th) << 16;
        mx = 64'(p_max_th) << 16;
        if (q_avg < mn)
            return 1'b0;
        if (q_avg >= mx)
            return 1'b1;
        lhs = (64'(rnd) * 64'(p_max_th - p_min_th)) << 16;
        rhs = 64'(p_max_prob) * (q_avg - mn);
        return lhs < rhs;
    endfunction

    function automatic rdq_out_t predict_queue(rdq_in_t it);
        rdq_out_t    r;
        int unsigned lim, v;
        r = '0;
        if (it.kind == 1'b0)
        begin
            q_avg = (((64'd65536 - 64'(p_weight)) * q_avg)
                     + 64'(p_weight) * (64'(q_count) << 16)) >> 16;
            q_avg = q_avg & 64'hFFFF_FFFF;
            if (red_rejects(it.red_random))
                r.early_dropped = 1'b1;
            else
            begin
                lim = (p_capacity > DEPTH - 1) ? DEPTH - 1 : p_capacity;
                if (q_count < DEPTH)
                begin
                    q_store[q_count] = '{it.packet_id, it.packet_priority, it.app_class};
                    q_count++;
                    r.accepted = 1'b1;
                end
                if (q_count > lim && q_count > 0)
                begin
                    v = choose_victim(it.drop_random);
                    r.victim_valid = 1'b1;
                    r.victim_id = q_store[v].id;
                    r.victim_priority = q_store[v].prio;
                    remove_entry(v);
                end
            end
        end
        else if (q_count > 0)
        begin
            r.departed_valid = 1'b1;
            r.departed_id = q_store[0].id;
            r.departed_priority = q_store[0].prio;
            r.departed_class = q_store[0].cls;
            remove_entry(0);
        end
        r.occupancy = 5'(q_count);
        r.average_occupancy = (q_avg > 64'hFFFFF) ? 20'hFFFFF : q_avg[19:0];
        return r;
    endfunction

    bit in_ready_sampled = 1'b0;
    bit out_ready_sampled = 1'b0;
    bit in_fire, out_fire;

    // driver
    int in_gap = 0;
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_ready_sampled))
        begin
            if (in_gap > 0)
            begin
                in_gap--;
                in_valid <= 1'b0;
            end
            else if (pending_items.size() > 0)
            begin
                in_data <= pending_items.pop_front();
                in_valid <= 1'b1;
                in_gap = $urandom_range(0, 17);
            end
            else
                in_valid <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        in_fire = in_valid && in_ready;
        out_fire = out_valid && out_ready;
        in_ready_sampled <= in_fire;
        out_ready_sampled <= out_fire;
        if (in_fire)
            expected_results = {expected_results, predict_queue(in_data)};
        if (out_fire)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result expected none actual %p", $time, out_data);
                errors++;
            end
            else
            begin
                rdq_out_t e;
                e = expected_results.pop_front();
                if (e != out_data)
                begin
                    $display("%0t: mismatch expected %p actual %p", $time, e, out_data);
                    errors++;
                end
            end
        end
        if (in_fire || out_fire || !rst_n)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // receiver
    int out_gap = 0;
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles--;
            out_ready <= 1'b0;
        end
        else if (out_ready_sampled)
        begin
            out_gap = $urandom_range(0, 17);
            out_ready <= (out_gap == 0);
        end
        else if (out_gap > 0)
        begin
            out_gap--;
            out_ready <= (out_gap == 0);
        end
        else
            out_ready <= 1'b1;
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            REG_DROP_POLICY: p_policy = val[1:0];
            REG_MIN_THRESH:  p_min_th = val[4:0];
            REG_MAX_THRESH:  p_max_th = val[4:0];
            REG_MAX_PROB:    p_max_prob = val;
            REG_AVG_WEIGHT:  p_weight = val;
            REG_CAPACITY:    p_capacity = val[3:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic drain();
        while (pending_items.size() > 0 || in_valid || expected_results.size() > 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    task automatic set_all(logic [1:0] pol, logic [4:0] mn, logic [4:0] mx,
                           logic [15:0] prob, logic [15:0] w, logic [3:0] cap);
        write_reg(REG_DROP_POLICY, 16'(pol));
        write_reg(REG_MIN_THRESH, 16'(mn));
        write_reg(REG_MAX_THRESH, 16'(mx));
        write_reg(REG_MAX_PROB, prob);
        write_reg(REG_AVG_WEIGHT, w);
        write_reg(REG_CAPACITY, 16'(cap));
    endtask

    function automatic rdq_in_t make_item(bit departure);
        rdq_in_t it;
        it.kind = departure;
        it.packet_id = 16'($urandom);
        it.packet_priority = 3'($urandom);
        it.app_class = 2'($urandom);
        it.red_random = 16'($urandom);
        it.drop_random = 16'($urandom);
        if ($urandom_range(0, 9) != 0)
            it.packet_priority = 3'($urandom_range(1, 5));
        return it;
    endfunction

    initial
    begin
        rdq_in_t it;
        p_policy = POLICY_PRIORITY; p_min_th = 5'd5; p_max_th = 5'd15;
        p_max_prob = 16'd6554; p_weight = 16'd131; p_capacity = 4'd10;
        q_count = 0; q_avg = 0;
        for (int i = 0; i < DEPTH; i++) q_store[i] = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: empty departure, extremes, all classes and priorities
        queue_item(make_item(1'b1));
        for (int i = 0; i < 14; i++)
        begin
            it = make_item(1'b0);
            it.packet_priority = 3'(i % 8);
            it.app_class = 2'(i % 4);
            it.packet_id = (i % 2) ? 16'hFFFF : 16'h0000;
            it.red_random = (i % 2) ? 16'hFFFF : 16'h0000;
            it.drop_random = (i % 3) ? 16'hFFFF : 16'h0000;
            queue_item(it);
        end
        for (int i = 0; i < 8; i++)
            queue_item(make_item(1'b1));
        drain();

        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase)
                0: set_all(POLICY_RANDOM, 5'd0, 5'd16, 16'hFFFF, 16'hFFFF, 4'd15);
                1: set_all(POLICY_CLASS, 5'd1, 5'd8, 16'd30000, 16'd8000, 4'd4);
                2: set_all(2'd3, 5'd16, 5'd1, 16'd0, 16'd0, 4'd0);
                3: set_all(POLICY_PRIORITY, 5'd2, 5'd12, 16'd65535, 16'd20000, 4'd8);
                4: set_all(POLICY_RANDOM, 5'd0, 5'd1, 16'd1000, 16'd65535, 4'd3);
                5: set_all(2'(phase % 3), 5'($urandom_range(0, 16)),
                           5'($urandom_range(1, 16)), 16'($urandom),
                           16'($urandom), 4'($urandom));
                6: set_all(POLICY_CLASS, 5'd0, 5'd16, 16'd0, 16'd4000, 4'd15);
                default: set_all(POLICY_PRIORITY, 5'd5, 5'd15, 16'd6554, 16'd131, 4'd10);
            endcase
            for (int i = 0; i < 150; i++)
                queue_item(make_item($urandom_range(0, 99) < 40));
            if (phase == 3)
                hold_cycles = 400;
            drain();
        end
        // leftover entries drained by departures
        for (int i = 0; i < 20; i++)
            queue_item(make_item(1'b1));
        drain();
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule

[files.f]
rtl/rdq_pkg.sv
rtl/rdq_ram.sv
rtl/red_drop_policy_packet_queue.sv
tb/red_drop_policy_packet_queue_test.sv
